@@ design/cec_pkg.sv @@
// ----------------------------------------------------------------------------
// cec_pkg
// Types, constants and arithmetic helpers shared by the coulomb and energy
// counter modules.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam int TIME_BITS   = 20;
  localparam int FRAC_BITS   = 16;
  localparam int ELAPSED_W   = 20;
  localparam int CAL_SH      = 32 - FRAC_BITS;
  localparam int HOUR_SH     = 32 + FRAC_BITS;
  localparam int MUL_W       = 34;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 100;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET = CFG_IDX_W'(3);

  localparam logic signed [31:0] CURRENT_GAIN_RST   = 32'sd10491085;
  localparam logic signed [31:0] CURRENT_OFFSET_RST = -32'sd816975;
  localparam logic signed [31:0] VOLTAGE_GAIN_RST   = 32'sd9960497;
  localparam logic signed [31:0] VOLTAGE_OFFSET_RST = -32'sd101;

  // Nearest integer to 2^64 / 3.6e9, used to turn microsecond sums into hours.
  localparam logic signed [MUL_W-1:0] HOUR_RECIP = MUL_W'(64'sd5124095576);

  typedef struct packed {
    logic signed [15:0]          raw_current;
    logic signed [15:0]          raw_voltage;
    logic        [ELAPSED_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] current_amps;
    logic signed [31:0] voltage_volts;
    logic signed [63:0] charge_amp_hours;
    logic signed [63:0] energy_watt_hours;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0]          raw_current;
    logic signed [15:0]          raw_voltage;
    logic        [TIME_BITS-1:0] dt;
  } job_t;

  typedef struct packed {
    logic signed [31:0] current_gain;
    logic signed [31:0] current_offset;
    logic signed [31:0] voltage_gain;
    logic signed [31:0] voltage_offset;
  } cfg_regs_t;

  function automatic logic [TIME_BITS-1:0] clamp_time(input logic [ELAPSED_W-1:0] e);
    logic [32:0] ext;
    logic [32:0] tmax;
    ext  = 33'(e);
    tmax = 33'((64'd1 << TIME_BITS) - 64'd1);
    if (ext > tmax) begin
      ext = tmax;
    end
    return ext[TIME_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-32:0] up;
    up = v[PROD_W-1:31];
    if ((&up) || (~|up)) begin
      return v[31:0];
    end else if (v[PROD_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-64:0] up;
    up = v[PROD_W-1:63];
    if ((&up) || (~|up)) begin
      return v[63:0];
    end else if (v[PROD_W-1]) begin
      return 64'sh8000_0000_0000_0000;
    end else begin
      return 64'sh7fff_ffff_ffff_ffff;
    end
  endfunction

  function automatic logic signed [63:0] sat64_acc(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-64:0] up;
    up = v[ACC_W-1:63];
    if ((&up) || (~|up)) begin
      return v[63:0];
    end else if (v[ACC_W-1]) begin
      return 64'sh8000_0000_0000_0000;
    end else begin
      return 64'sh7fff_ffff_ffff_ffff;
    end
  endfunction

  // Rounding half up is the floor shift plus the last bit shifted out.
  function automatic logic signed [31:0] calibrate(input logic signed [PROD_W-1:0] p,
                                                   input logic signed [31:0] off);
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W-1:0] q;
    sh = p >>> CAL_SH;
    q  = sh + PROD_W'(p[CAL_SH-1]) + PROD_W'(off);
    return sat32(q);
  endfunction

  function automatic logic signed [63:0] round_frac(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] q;
    sh = acc >>> FRAC_BITS;
    q  = sh + ACC_W'(acc[FRAC_BITS-1]);
    return sat64_acc(q);
  endfunction

  function automatic logic signed [63:0] round_hour(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] q;
    sh = acc >>> HOUR_SH;
    q  = sh + ACC_W'(acc[HOUR_SH-1]);
    return sat64_acc(q);
  endfunction

endpackage

@@ design/cec_front.sv @@
// ----------------------------------------------------------------------------
// cec_front
// Input stage: registers each sample pair, saturates the interval to the
// timer width and hands the job to the queue.
// ----------------------------------------------------------------------------
module cec_front import cec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push_valid,
  input  logic     push_ready,
  output job_t     push_data
);

  logic hold_valid_r;
  job_t hold_r;

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r.raw_current <= in_data.raw_current;
      hold_r.raw_voltage <= in_data.raw_voltage;
      hold_r.dt          <= clamp_time(in_data.elapsed_us);
    end
  end

endmodule

@@ design/cec_queue.sv @@
// ----------------------------------------------------------------------------
// cec_queue
// Short job queue that decouples the input stage from the arithmetic back end.
// ----------------------------------------------------------------------------
module cec_queue import cec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/cec_back.sv @@
// ----------------------------------------------------------------------------
// cec_back
// Arithmetic back end: a sequencer drives one shared 34x34 signed multiplier
// through calibration, charge and energy steps and the hour conversions,
// keeps the two saturating sums and holds the result register.
// ----------------------------------------------------------------------------
module cec_back import cec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MI   = 4'd1;
  localparam logic [3:0] ST_MV   = 4'd2;
  localparam logic [3:0] ST_MQ   = 4'd3;
  localparam logic [3:0] ST_MP   = 4'd4;
  localparam logic [3:0] ST_ML   = 4'd5;
  localparam logic [3:0] ST_MH   = 4'd6;
  localparam logic [3:0] ST_MA   = 4'd7;
  localparam logic [3:0] ST_MB   = 4'd8;
  localparam logic [3:0] ST_EA   = 4'd9;
  localparam logic [3:0] ST_EL   = 4'd10;
  localparam logic [3:0] ST_EH   = 4'd11;
  localparam logic [3:0] ST_EB   = 4'd12;
  localparam logic [3:0] ST_WH   = 4'd13;

  logic [3:0]               state_r;
  logic [3:0]               state_nxt;
  logic signed [15:0]       raw_i_r;
  logic signed [15:0]       raw_v_r;
  logic [TIME_BITS-1:0]     dt_r;
  logic signed [31:0]       cur_r;
  logic signed [31:0]       vol_r;
  logic signed [31:0]       vch_r;
  logic signed [63:0]       estep_r;
  logic signed [63:0]       ah_r;
  logic signed [63:0]       charge_r;
  logic signed [63:0]       energy_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic                     out_valid_r;
  out_item_t                out_r;
  logic                     emit;

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit      = (state_r == ST_WH) && (!out_valid_r || out_ready);

  // Operand select for the shared multiplier; its product lands in p_r and
  // is consumed in the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MI: begin
        mul_a = MUL_W'(raw_i_r);
        mul_b = MUL_W'(cfg.current_gain);
      end
      ST_MV: begin
        mul_a = MUL_W'(raw_v_r);
        mul_b = MUL_W'(cfg.voltage_gain);
      end
      ST_MQ: begin
        mul_a = MUL_W'(cur_r);
        mul_b = MUL_W'(dt_r);
      end
      ST_MP: begin
        mul_a = MUL_W'(vol_r);
        mul_b = MUL_W'(cur_r);
      end
      ST_ML: begin
        mul_a = MUL_W'(p_r[31:0]);
        mul_b = MUL_W'(dt_r);
      end
      ST_MH: begin
        mul_a = MUL_W'(vch_r);
        mul_b = MUL_W'(dt_r);
      end
      ST_MA: begin
        mul_a = MUL_W'(charge_r[31:0]);
        mul_b = HOUR_RECIP;
      end
      ST_MB: begin
        mul_a = MUL_W'($signed(charge_r[63:32]));
        mul_b = HOUR_RECIP;
      end
      ST_EL: begin
        mul_a = MUL_W'(energy_r[31:0]);
        mul_b = HOUR_RECIP;
      end
      ST_EH: begin
        mul_a = MUL_W'($signed(energy_r[63:32]));
        mul_b = HOUR_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = job_valid ? ST_MI : ST_IDLE;
      ST_WH:   state_nxt = emit ? ST_IDLE : ST_WH;
      ST_MI, ST_MV, ST_MQ, ST_MP, ST_ML, ST_MH,
      ST_MA, ST_MB, ST_EA, ST_EL, ST_EH, ST_EB: state_nxt = state_r + 4'd1;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      charge_r    <= '0;
      energy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_MP) begin
        charge_r <= sat64(PROD_W'(charge_r) + p_r);
      end
      if (state_r == ST_EA) begin
        energy_r <= sat64(PROD_W'(energy_r) + PROD_W'(estep_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        raw_i_r <= job.raw_current;
        raw_v_r <= job.raw_voltage;
        dt_r    <= job.dt;
      end
      ST_MV: cur_r <= calibrate(p_r, cfg.current_offset);
      ST_MQ: vol_r <= calibrate(p_r, cfg.voltage_offset);
      ST_ML: vch_r <= p_r[63:32];
      // Energy step: voltage*current split in two 32-bit halves, each times dt.
      ST_MH: acc_r <= ACC_W'(p_r);
      ST_MA: acc_r <= acc_r + (ACC_W'(p_r) <<< 32);
      ST_MB: begin
        estep_r <= round_frac(acc_r);
        acc_r   <= ACC_W'(p_r);
      end
      ST_EA: acc_r <= acc_r + (ACC_W'(p_r) <<< 32);
      ST_EL: ah_r  <= round_hour(acc_r);
      ST_EH: acc_r <= ACC_W'(p_r);
      ST_EB: acc_r <= acc_r + (ACC_W'(p_r) <<< 32);
      default: begin
      end
    endcase
    if (emit) begin
      out_r.current_amps      <= cur_r;
      out_r.voltage_volts     <= vol_r;
      out_r.charge_amp_hours  <= ah_r;
      out_r.energy_watt_hours <= round_hour(acc_r);
    end
  end

endmodule

@@ design/coulomb_and_energy_counter_core.sv @@
// ----------------------------------------------------------------------------
// coulomb_and_energy_counter_core
// Battery coulomb counter: calibrates current and voltage samples, keeps
// saturating charge and energy sums and reports both in hours.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_ready    in_item_t (raw counts, interval)
//  out_      output     out_valid/out_ready  out_item_t (A, V, Ah, Wh)
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data (32 bits)
//
// The back end takes one job at a time and runs thirteen sequenced steps
// around a single shared 34x34 multiplier used ten times; it takes the next
// job only after the last result has entered the output register.
// Reset loads the default calibration and clears both sums; no clearing pass.
// A stalled result holds in the output register; the back end still finishes
// the next item up to its final step, and the front stage and queue take up
// to three more items. The configuration port is always ready.
// ----------------------------------------------------------------------------
module coulomb_and_energy_counter_core import cec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_regs_t cfg_r;
  logic      push_valid;
  logic      push_ready;
  job_t      push_data;
  logic      job_valid;
  logic      job_ready;
  job_t      job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_gain   <= CURRENT_GAIN_RST;
      cfg_r.current_offset <= CURRENT_OFFSET_RST;
      cfg_r.voltage_gain   <= VOLTAGE_GAIN_RST;
      cfg_r.voltage_offset <= VOLTAGE_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURRENT_GAIN:   cfg_r.current_gain   <= cfg_data;
        REG_CURRENT_OFFSET: cfg_r.current_offset <= cfg_data;
        REG_VOLTAGE_GAIN:   cfg_r.voltage_gain   <= cfg_data;
        REG_VOLTAGE_OFFSET: cfg_r.voltage_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  cec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job)
  );

  cec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ design/cec_checker.sv @@
// ----------------------------------------------------------------------------
// cec_checker
// Port-level checks for the coulomb and energy counter, bound to the top.
// ----------------------------------------------------------------------------
module cec_checker import cec_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Input stage, queue, the item in the back end and the output register.
  localparam logic [2:0] MAX_IN_FLIGHT = 3'(QUEUE_DEPTH + 3);

  logic [2:0] pend_r;
  logic [2:0] pend_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without an outstanding input transfer");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == MAX_IN_FLIGHT |-> !in_ready)
    else $error("input accepted beyond the block's capacity");

endmodule

bind coulomb_and_energy_counter_core cec_checker u_cec_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ tb/sv/cec_reading_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_reading_checker
// Watches the sample, result and calibration channels of the coulomb and
// energy counter, keeps its own copy of the calibration and of both running
// sums, predicts every result and compares it field by field in order.
// ----------------------------------------------------------------------------
module cec_reading_checker import cec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);

  // Integer nearest to 2^64 / 3.6e9: microsecond sums times this, shifted
  // down by 32 + FRAC_BITS, give Q48.16 hours.
  localparam logic signed [127:0] USEC_TO_HOUR_RECIP = 128'sd5124095576;

  cfg_regs_t          calib;
  logic signed [63:0] charge_acc;
  logic signed [63:0] energy_acc;
  out_item_t          expected_readings[$];
  out_item_t          oldest;
  int                 result_count;

  initial begin
    errors  = 0;
    pending = 0;
    result_count = 0;
  end

  function automatic logic signed [63:0] fit_i64(input logic signed [127:0] v);
    if (v > 128'sh7fff_ffff_ffff_ffff) begin
      return 64'sh7fff_ffff_ffff_ffff;
    end else if (v < -128'sh8000_0000_0000_0000) begin
      return 64'sh8000_0000_0000_0000;
    end
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] fit_i32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -128'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Exact product, then a right shift that rounds halves toward plus infinity.
  function automatic logic signed [127:0] mul_round(input logic signed [127:0] a,
                                                    input logic signed [127:0] b,
                                                    input int sh);
    logic signed [127:0] half;
    half = 128'sd1 <<< (sh - 1);
    return (a * b + half) >>> sh;
  endfunction

  function automatic logic signed [31:0] calibrated(input logic signed [15:0] raw,
                                                    input logic signed [31:0] gain,
                                                    input logic signed [31:0] off);
    logic signed [127:0] scaled;
    scaled = mul_round(raw, gain, CAL_SH) + off;
    return fit_i32(scaled);
  endfunction

  function automatic out_item_t predict_reading(input in_item_t smp);
    out_item_t           res;
    logic [63:0]         dt;
    logic signed [127:0] dt_w;
    logic signed [127:0] amps_w;
    logic signed [127:0] volts_w;
    dt = smp.elapsed_us;
    if (dt > (64'd1 << TIME_BITS) - 64'd1) begin
      dt = (64'd1 << TIME_BITS) - 64'd1;
    end
    dt_w = dt;
    res.current_amps  = calibrated(smp.raw_current, calib.current_gain, calib.current_offset);
    res.voltage_volts = calibrated(smp.raw_voltage, calib.voltage_gain, calib.voltage_offset);
    amps_w  = res.current_amps;
    volts_w = res.voltage_volts;
    charge_acc = fit_i64(charge_acc + amps_w * dt_w);
    energy_acc = fit_i64(energy_acc + fit_i64(mul_round(volts_w * amps_w, dt_w, FRAC_BITS)));
    res.charge_amp_hours  = fit_i64(mul_round(charge_acc, USEC_TO_HOUR_RECIP, HOUR_SH));
    res.energy_watt_hours = fit_i64(mul_round(energy_acc, USEC_TO_HOUR_RECIP, HOUR_SH));
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      calib.current_gain   = CURRENT_GAIN_RST;
      calib.current_offset = CURRENT_OFFSET_RST;
      calib.voltage_gain   = VOLTAGE_GAIN_RST;
      calib.voltage_offset = VOLTAGE_OFFSET_RST;
      charge_acc = '0;
      energy_acc = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no sample outstanding",
                                    result_count));
        end else begin
          oldest = expected_readings.pop_front();
          check_field("current_amps", out_data.current_amps, oldest.current_amps);
          check_field("voltage_volts", out_data.voltage_volts, oldest.voltage_volts);
          check_field("charge_amp_hours", out_data.charge_amp_hours,
                      oldest.charge_amp_hours);
          check_field("energy_watt_hours", out_data.energy_watt_hours,
                      oldest.energy_watt_hours);
        end
        result_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURRENT_GAIN:   calib.current_gain   = cfg_data;
          REG_CURRENT_OFFSET: calib.current_offset = cfg_data;
          REG_VOLTAGE_GAIN:   calib.voltage_gain   = cfg_data;
          REG_VOLTAGE_OFFSET: calib.voltage_offset = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(in_data));
      end
    end
    pending = expected_readings.size();
  end

endmodule

@@ tb/sv/tb_coulomb_and_energy_counter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coulomb_and_energy_counter_core
// Drives sample pairs and calibration writes into the coulomb and energy
// counter under random stalls on both channels; a checker beside the block
// predicts and compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_coulomb_and_energy_counter_core;
  import cec_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int errors;
  int pending;
  bit steady_run = 1'b0;

  always #4 clk = ~clk;

  coulomb_and_energy_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cec_reading_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic in_item_t reading(input logic signed [15:0] cur,
                                       input logic signed [15:0] vol,
                                       input logic [ELAPSED_W-1:0] us);
    in_item_t r;
    r.raw_current = cur;
    r.raw_voltage = vol;
    r.elapsed_us  = us;
    return r;
  endfunction

  function automatic logic signed [15:0] random_count();
    logic [15:0] mag;
    mag = 16'($urandom_range(0, 300));
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return $urandom_range(0, 1) ? mag : -mag;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return ELAPSED_W'($urandom_range(1, 2000));
      default: return ELAPSED_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_reading();
    return reading(random_count(), random_count(), random_elapsed());
  endfunction

  // Wild coefficients use the whole 32-bit range; tame ones stay small enough
  // that the sums mostly remain in range.
  function automatic logic [31:0] random_coeff(input bit wild, input int span);
    logic [31:0] mag;
    mag = $urandom_range(0, span);
    if (wild) begin
      return $urandom;
    end
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  task automatic send_reading(input in_item_t smp);
    int gap;
    @(negedge clk);
    if (!steady_run && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_calibration(input logic [31:0] cur_gain, input logic [31:0] cur_off,
                                  input logic [31:0] vol_gain, input logic [31:0] vol_off);
    write_reg(REG_CURRENT_GAIN, cur_gain);
    write_reg(REG_CURRENT_OFFSET, cur_off);
    write_reg(REG_VOLTAGE_GAIN, vol_gain);
    write_reg(REG_VOLTAGE_OFFSET, vol_off);
  endtask

  // Result side: random bursts of ready and stall.
  initial begin
    int hold;
    bit open;
    hold = 0;
    open = 1'b1;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        open = ($urandom_range(0, 2) != 0);
        hold = open ? $urandom_range(1, 40) : $urandom_range(1, 14);
      end
      hold--;
      out_ready <= open || steady_run;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: field extremes, alternating bit patterns and the
    // longest interval.
    send_reading(reading(16'sd0, 16'sd0, '0));
    send_reading(reading(16'sh7fff, 16'sh7fff, 20'd1));
    send_reading(reading(16'sh8000, 16'sh8000, 20'd1000));
    send_reading(reading(16'sh7fff, 16'sh8000, '1));
    send_reading(reading(16'sh8000, 16'sh7fff, '1));
    send_reading(reading(16'sd1, -16'sd1, 20'd12345));
    send_reading(reading(16'h5555, 16'haaaa, 20'h55555));
    send_reading(reading(16'haaaa, 16'h5555, 20'haaaaa));
    wait_idle();

    // Largest coefficients: calibration clamps high and the energy sum
    // saturates and sticks.
    load_calibration(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_reading(reading(16'sh7fff, 16'sh7fff, '1));
    send_reading(reading(16'sh7fff, 16'sh7fff, '1));
    send_reading(reading(16'sh8000, 16'sh7fff, '1));
    send_reading(reading(16'sd0, 16'sd0, '0));
    wait_idle();

    // Smallest coefficients: calibration clamps low.
    load_calibration(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_reading(reading(16'sh7fff, 16'sh7fff, '1));
    send_reading(reading(16'sh8000, 16'sh8000, '1));
    send_reading(reading(16'sh7fff, 16'sh8000, 20'd7));
    send_reading(reading(16'sd0, 16'sd0, '1));
    wait_idle();

    // Negative current against positive voltage pulls the stuck energy sum
    // back from its limit.
    load_calibration(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_reading(reading(16'sh8000, 16'sh7fff, '1));
    send_reading(reading(16'sh8000, 16'sh7fff, '1));
    send_reading(reading(16'sh7fff, 16'sh0000, 20'd3));
    wait_idle();

    load_calibration('0, '0, '0, '0);
    send_reading(reading(16'sh7fff, 16'sh8000, '1));
    send_reading(reading(16'sh8000, 16'sh7fff, '1));

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 5) begin
        steady_run = 1'b1;
      end
      if (p == 0) begin
        load_calibration(CURRENT_GAIN_RST, CURRENT_OFFSET_RST,
                         VOLTAGE_GAIN_RST, VOLTAGE_OFFSET_RST);
      end else begin
        load_calibration(random_coeff(p % 2, 1 << 25), random_coeff(p % 2, 1 << 22),
                         random_coeff(p % 2, 1 << 25), random_coeff(p % 2, 1 << 22));
      end
      repeat (250) send_reading(random_reading());
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
